[hw/rtl/phc_pkg.sv]
`timescale 1ns / 1ps

package phc_pkg;

   // field widths of the request, the response and the gain registers
   localparam int TEMP_W       = 16;
   localparam int ELAPSED_W    = 16;
   localparam int GAIN_W       = 16;
   localparam int DUTY_FIELD_W = 8;
   localparam int CLAMP_W      = 2;
   localparam int CSR_INDEX_W  = 2;

   // duty ceiling and the widths that follow from it
   localparam int     DUTY_MAX     = 255;
   localparam int     DUTY_W       = $clog2(DUTY_MAX + 1);
   localparam logic [DUTY_FIELD_W-1:0] DUTY_MAX_LOW = DUTY_FIELD_W'(DUTY_MAX);

   // fixed scale factors of the controller arithmetic
   localparam int     KP_SCALE  = 1000;
   localparam int     KD_SCALE  = 1000000;
   localparam int     DEN_SCALE = 4096000;
   localparam longint I_MAX     = longint'(DUTY_MAX) * longint'(DEN_SCALE);
   localparam int     I_MAX_W   = $clog2(I_MAX + 1);
   localparam longint DEN_MAX   = longint'(DEN_SCALE) * longint'((1 << ELAPSED_W) - 1);
   localparam int     DEN_W     = $clog2(DEN_MAX + 1);

   // datapath widths
   localparam int ERR_W  = TEMP_W + 1;
   localparam int DE_W   = TEMP_W + 2;
   localparam int INC_W  = ERR_W + ELAPSED_W + 1;
   localparam int SUM_W  = 48;
   localparam int ACC_W  = 64;
   localparam int MUL_W  = (I_MAX_W + 1 > INC_W) ? I_MAX_W + 1 : INC_W;
   localparam int PROD_W = 2 * MUL_W;
   localparam int DIV_CNT_W = (DUTY_W > 1) ? $clog2(DUTY_W) : 1;

   // gain reset values
   localparam logic [GAIN_W-1:0] GAIN_P_RESET = 16'd2048;
   localparam logic [GAIN_W-1:0] GAIN_I_RESET = 16'd205;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET = 16'd5120;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D = 2'd2;

   // clamp codes
   localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
   localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
   localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

   typedef struct packed {
      logic                     operation;
      logic signed [TEMP_W-1:0] measured_temp;
      logic signed [TEMP_W-1:0] target_temp;
      logic [ELAPSED_W-1:0]     elapsed_ms;
   } phc_req_type;

   typedef struct packed {
      logic [DUTY_FIELD_W-1:0] duty;
      logic [CLAMP_W-1:0]      clamp_state;
   } phc_rsp_type;

   // datapath micro-operations, issued by the controller one per cycle at most
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_ET,
      OP_MUL_KP,
      OP_MUL_P,
      OP_MUL_KI,
      OP_MUL_KD,
      OP_MUL_IT,
      OP_MUL_D,
      OP_MUL_DEN,
      OP_MUL_LIM,
      OP_CLAMP,
      OP_DIV,
      OP_EMIT
   } phc_op_type;

   typedef struct packed {
      phc_op_type op;
   } phc_cmd_type;

   typedef struct packed {
      logic quick;
   } phc_status_type;

endpackage

[hw/rtl/phc_ctrl.sv]
`timescale 1ns / 1ps

module phc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  phc_pkg::phc_status_type status,
   output phc_pkg::phc_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_MUL   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_EMIT  = 5'b10000
   } phc_state_type;

   phc_state_type                   state_ff, state_in;
   phc_pkg::phc_op_type             op_ff, op_in;
   logic [phc_pkg::DIV_CNT_W-1:0]   div_ff, div_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            out_free;

   // step through the multiply sequence
   function automatic phc_pkg::phc_op_type next_op(input phc_pkg::phc_op_type op);
      phc_pkg::phc_op_type nxt;
      unique case (op)
         phc_pkg::OP_MUL_ET:  nxt = phc_pkg::OP_MUL_KP;
         phc_pkg::OP_MUL_KP:  nxt = phc_pkg::OP_MUL_P;
         phc_pkg::OP_MUL_P:   nxt = phc_pkg::OP_MUL_KI;
         phc_pkg::OP_MUL_KI:  nxt = phc_pkg::OP_MUL_KD;
         phc_pkg::OP_MUL_KD:  nxt = phc_pkg::OP_MUL_IT;
         phc_pkg::OP_MUL_IT:  nxt = phc_pkg::OP_MUL_D;
         phc_pkg::OP_MUL_D:   nxt = phc_pkg::OP_MUL_DEN;
         phc_pkg::OP_MUL_DEN: nxt = phc_pkg::OP_MUL_LIM;
         phc_pkg::OP_MUL_LIM: nxt = phc_pkg::OP_CLAMP;
         default:             nxt = phc_pkg::OP_CLAMP;
      endcase
      return nxt;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // sequence one request at a time
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      div_in       = div_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = phc_pkg::OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = phc_pkg::OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            op_in = phc_pkg::OP_MUL_ET;
            if (status.quick) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.op = op_ff;
            op_in  = next_op(op_ff);
            div_in = '0;
            if (op_ff == phc_pkg::OP_CLAMP) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.op = phc_pkg::OP_DIV;
            div_in = div_ff + 1'b1;
            if (div_ff == phc_pkg::DIV_CNT_W'(phc_pkg::DUTY_W - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.op       = phc_pkg::OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      div_ff <= div_in;
   end

endmodule

[hw/rtl/phc_dp.sv]
`timescale 1ns / 1ps

module phc_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  phc_pkg::phc_req_type              req_data,
   output phc_pkg::phc_rsp_type              rsp_data,
   input  logic                              csr_write,
   input  logic [phc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [phc_pkg::GAIN_W-1:0]        csr_data,
   input  phc_pkg::phc_cmd_type              cmd,
   output phc_pkg::phc_status_type           status
);

   localparam int ERR_W   = phc_pkg::ERR_W;
   localparam int DE_W    = phc_pkg::DE_W;
   localparam int INC_W   = phc_pkg::INC_W;
   localparam int SUM_W   = phc_pkg::SUM_W;
   localparam int ACC_W   = phc_pkg::ACC_W;
   localparam int MUL_W   = phc_pkg::MUL_W;
   localparam int PROD_W  = phc_pkg::PROD_W;
   localparam int I_MAX_W = phc_pkg::I_MAX_W;
   localparam int DEN_W   = phc_pkg::DEN_W;
   localparam int DUTY_W  = phc_pkg::DUTY_W;
   localparam int GAIN_W  = phc_pkg::GAIN_W;
   localparam int T_W     = phc_pkg::ELAPSED_W;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   // gains
   logic [GAIN_W-1:0]              gain_p_ff, gain_p_in;
   logic [GAIN_W-1:0]              gain_i_ff, gain_i_in;
   logic [GAIN_W-1:0]              gain_d_ff, gain_d_in;

   // controller state
   logic signed [SUM_W-1:0]        integral_ff, integral_in;
   logic signed [ERR_W-1:0]        prev_err_ff, prev_err_in;
   logic                           started_ff, started_in;

   // working registers
   logic signed [ERR_W-1:0]        err_ff, err_in;
   logic signed [DE_W-1:0]         de_ff, de_in;
   logic [T_W-1:0]                 t_ff, t_in;
   logic                           quick_ff, quick_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [INC_W-1:0]        inc_ff, inc_in;
   logic signed [SUM_W-1:0]        s_ff, s_in;
   logic [I_MAX_W-1:0]             s_op_ff, s_op_in;
   logic [I_MAX_W-1:0]             inum_ff, inum_in;
   logic signed [MUL_W-1:0]        kdde_ff, kdde_in;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic [DEN_W-1:0]               den_ff, den_in;
   logic [phc_pkg::CLAMP_W-1:0]    clamp_ff, clamp_in;
   logic [ACC_W-1:0]               rem_ff, rem_in;
   logic [ACC_W-1:0]               dsh_ff, dsh_in;
   logic [DUTY_W-1:0]              q_ff, q_in;
   phc_pkg::phc_rsp_type           rsp_ff, rsp_in;

   logic signed [MUL_W-1:0]        mul_a, mul_b;
   logic signed [ERR_W-1:0]        err_new;
   logic signed [SUM_W:0]          sum_wide;
   logic                           err_pos, err_neg, hold_sum, div_bit;

   assign status.quick = quick_ff;
   assign rsp_data     = rsp_ff;

   assign err_new = ERR_W'(req_data.target_temp) - ERR_W'(req_data.measured_temp);
   assign err_pos = !err_ff[ERR_W-1] && (err_ff != '0);
   assign err_neg = err_ff[ERR_W-1];
   assign sum_wide = (SUM_W+1)'(integral_ff) + (SUM_W+1)'(prod_ff);
   assign div_bit  = (rem_ff >= dsh_ff);

   // shared multiplier, registered every cycle
   assign prod_in = mul_a * mul_b;

   // gain writes
   always_comb begin
      gain_p_in = gain_p_ff;
      gain_i_in = gain_i_ff;
      gain_d_in = gain_d_ff;
      if (csr_write) begin
         unique case (csr_index)
            phc_pkg::CSR_GAIN_P: gain_p_in = csr_data;
            phc_pkg::CSR_GAIN_I: gain_i_in = csr_data;
            phc_pkg::CSR_GAIN_D: gain_d_in = csr_data;
            default: ;
         endcase
      end
   end

   // decode the micro-operation
   always_comb begin
      integral_in = integral_ff;
      prev_err_in = prev_err_ff;
      started_in  = started_ff;
      err_in      = err_ff;
      de_in       = de_ff;
      t_in        = t_ff;
      quick_in    = quick_ff;
      inc_in      = inc_ff;
      s_in        = s_ff;
      s_op_in     = s_op_ff;
      inum_in     = inum_ff;
      kdde_in     = kdde_ff;
      acc_in      = acc_ff;
      den_in      = den_ff;
      clamp_in    = clamp_ff;
      rem_in      = rem_ff;
      dsh_in      = dsh_ff;
      q_in        = q_ff;
      rsp_in      = rsp_ff;
      hold_sum    = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      unique case (cmd.op)
         phc_pkg::OP_NONE: ;
         phc_pkg::OP_LOAD: begin
            err_in   = err_new;
            de_in    = DE_W'(err_new) - DE_W'(prev_err_ff);
            t_in     = (req_data.elapsed_ms == '0) ? T_W'(1) : req_data.elapsed_ms;
            quick_in = req_data.operation || !started_ff;
            if (req_data.operation) begin
               integral_in = '0;
               prev_err_in = '0;
               started_in  = 1'b0;
            end else begin
               prev_err_in = err_new;
               started_in  = 1'b1;
            end
         end
         phc_pkg::OP_MUL_ET: begin
            mul_a = MUL_W'(err_ff);
            mul_b = MUL_W'(t_ff);
         end
         phc_pkg::OP_MUL_KP: begin
            // take e*t and fold it into the saturated running sum
            inc_in = INC_W'(prod_ff);
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
               s_in = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
               s_in = SUM_W'(sum_wide);
            end
            mul_a = MUL_W'(gain_p_ff);
            mul_b = MUL_W'(phc_pkg::KP_SCALE);
         end
         phc_pkg::OP_MUL_P: begin
            // limit the sum before the integral gain; only the clamp matters
            if (s_ff[SUM_W-1] || (s_ff == '0)) begin
               s_op_in = '0;
            end else if (s_ff > SUM_W'(phc_pkg::I_MAX)) begin
               s_op_in = I_MAX_W'(phc_pkg::I_MAX);
            end else begin
               s_op_in = I_MAX_W'(s_ff);
            end
            mul_a = MUL_W'(prod_ff);
            mul_b = MUL_W'(inc_ff);
         end
         phc_pkg::OP_MUL_KI: begin
            acc_in = ACC_W'(prod_ff);
            mul_a  = MUL_W'(gain_i_ff);
            mul_b  = MUL_W'(s_op_ff);
         end
         phc_pkg::OP_MUL_KD: begin
            if (prod_ff > PROD_W'(phc_pkg::I_MAX)) begin
               inum_in = I_MAX_W'(phc_pkg::I_MAX);
            end else begin
               inum_in = I_MAX_W'(prod_ff);
            end
            mul_a = MUL_W'(gain_d_ff);
            mul_b = MUL_W'(de_ff);
         end
         phc_pkg::OP_MUL_IT: begin
            kdde_in = MUL_W'(prod_ff);
            mul_a   = MUL_W'(inum_ff);
            mul_b   = MUL_W'(t_ff);
         end
         phc_pkg::OP_MUL_D: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            mul_a  = kdde_ff;
            mul_b  = MUL_W'(phc_pkg::KD_SCALE);
         end
         phc_pkg::OP_MUL_DEN: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
            mul_a  = MUL_W'(t_ff);
            mul_b  = MUL_W'(phc_pkg::DEN_SCALE);
         end
         phc_pkg::OP_MUL_LIM: begin
            den_in = DEN_W'(prod_ff);
            mul_a  = MUL_W'(t_ff);
            mul_b  = MUL_W'(phc_pkg::I_MAX);
         end
         phc_pkg::OP_CLAMP: begin
            // compare against the duty ceiling, then back off the integral
            if (acc_ff > ACC_W'(prod_ff)) begin
               clamp_in = phc_pkg::CLAMP_HIGH;
            end else if (acc_ff[ACC_W-1]) begin
               clamp_in = phc_pkg::CLAMP_LOW;
            end else begin
               clamp_in = phc_pkg::CLAMP_NONE;
            end
            hold_sum = (gain_i_ff != '0) &&
                       (((clamp_in == phc_pkg::CLAMP_HIGH) && err_pos) ||
                        ((clamp_in == phc_pkg::CLAMP_LOW) && err_neg));
            if (!hold_sum) begin
               integral_in = s_ff;
            end
            rem_in = ACC_W'(acc_ff);
            dsh_in = ACC_W'(den_ff) << (DUTY_W - 1);
            q_in   = '0;
         end
         phc_pkg::OP_DIV: begin
            // restoring division, one quotient bit a cycle
            if (div_bit) begin
               rem_in = rem_ff - dsh_ff;
            end
            dsh_in = dsh_ff >> 1;
            q_in   = (q_ff << 1) | DUTY_W'(div_bit);
         end
         phc_pkg::OP_EMIT: begin
            if (quick_ff) begin
               rsp_in.duty        = '0;
               rsp_in.clamp_state = phc_pkg::CLAMP_NONE;
            end else begin
               rsp_in.clamp_state = clamp_ff;
               if (clamp_ff == phc_pkg::CLAMP_HIGH) begin
                  rsp_in.duty = phc_pkg::DUTY_MAX_LOW;
               end else if (clamp_ff == phc_pkg::CLAMP_LOW) begin
                  rsp_in.duty = '0;
               end else begin
                  rsp_in.duty = phc_pkg::DUTY_FIELD_W'(q_ff);
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff   <= phc_pkg::GAIN_P_RESET;
         gain_i_ff   <= phc_pkg::GAIN_I_RESET;
         gain_d_ff   <= phc_pkg::GAIN_D_RESET;
         integral_ff <= '0;
         prev_err_ff <= '0;
         started_ff  <= 1'b0;
      end else begin
         gain_p_ff   <= gain_p_in;
         gain_i_ff   <= gain_i_in;
         gain_d_ff   <= gain_d_in;
         integral_ff <= integral_in;
         prev_err_ff <= prev_err_in;
         started_ff  <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      de_ff    <= de_in;
      t_ff     <= t_in;
      quick_ff <= quick_in;
      prod_ff  <= prod_in;
      inc_ff   <= inc_in;
      s_ff     <= s_in;
      s_op_ff  <= s_op_in;
      inum_ff  <= inum_in;
      kdde_ff  <= kdde_in;
      acc_ff   <= acc_in;
      den_ff   <= den_in;
      clamp_ff <= clamp_in;
      rem_ff   <= rem_in;
      dsh_ff   <= dsh_in;
      q_ff     <= q_in;
      rsp_ff   <= rsp_in;
   end

endmodule

[hw/rtl/pid_heater_controller.sv]
`timescale 1ns / 1ps
// Compute request: a load and a decode step, nine products through the one shared
// multiplier, one compare step, and one quotient bit a cycle (8 bits at a 255 duty
// ceiling) in the divider; the next request is taken only once the response is issued.
// A clear request, or the first compute after reset or a clear, skips the products and
// the divider and answers with zero duty.
// Synchronous active-high reset clears the integral, previous error and started flag,
// returns the gains to their defaults and drops the response valid.

module pid_heater_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  phc_pkg::phc_req_type            req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output phc_pkg::phc_rsp_type            rsp_data,
   input  logic                            csr_write,
   input  logic [phc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [phc_pkg::GAIN_W-1:0]      csr_data
);

   phc_pkg::phc_cmd_type    cmd;
   phc_pkg::phc_status_type status;

   // sequencer
   phc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, state and response register
   phc_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

[hw/rtl/phc_checker.sv]
`timescale 1ns / 1ps

module phc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input phc_pkg::phc_rsp_type rsp_data
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed or dropped");

   // stall the request side once a request is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous request in progress");

   // clamped high drives the ceiling
   a_clamp_high: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.clamp_state == phc_pkg::CLAMP_HIGH))
      |-> (rsp_data.duty == phc_pkg::DUTY_MAX_LOW))
      else $error("clamped-high response without ceiling duty");

   // clamped low drives zero
   a_clamp_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.clamp_state == phc_pkg::CLAMP_LOW))
      |-> (rsp_data.duty == '0))
      else $error("clamped-low response with nonzero duty");

   // come out of reset empty and ready
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("not idle after reset");

endmodule

bind pid_heater_controller phc_checker u_phc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[dv/pid_heater_controller_checker.sv]
`timescale 1ns / 1ps

module pid_heater_controller_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  phc_pkg::phc_req_type            req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  phc_pkg::phc_rsp_type            rsp_data,
   input  logic                            csr_write,
   input  logic [phc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [phc_pkg::GAIN_W-1:0]      csr_data,
   output int                              fail_count,
   output int                              pending,
   output int                              checked_count,
   output int                              high_count,
   output int                              low_count
);
   import phc_pkg::*;

   localparam longint DUTY_CEIL    = DUTY_MAX;
   localparam longint TICK_SCALE   = 4096000;
   localparam longint SUM_HIGH     = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint SUM_LOW      = -(longint'(1) <<< (SUM_W - 1));

   // gains and controller state as the block should hold them
   logic [GAIN_W-1:0] gain_p;
   logic [GAIN_W-1:0] gain_i;
   logic [GAIN_W-1:0] gain_d;
   longint            integ_sum;
   int                prev_err;
   bit                primed;

   phc_rsp_type duty_queue[$];
   phc_rsp_type want;

   // print one line per mismatch and count it
   task automatic report_mismatch(input string what);
      fail_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // work out the duty and clamp state for one request and advance the state
   function automatic phc_rsp_type predict_duty(input phc_req_type item);
      phc_rsp_type        result;
      int                 err;
      int                 derr;
      longint             t;
      longint             s;
      longint             i_num;
      longint             den;
      longint             total;
      longint             duty_full;
      logic [CLAMP_W-1:0] clamp;

      result.duty        = '0;
      result.clamp_state = CLAMP_NONE;

      // state clear request
      if (item.operation) begin
         integ_sum = 0;
         prev_err  = 0;
         primed    = 1'b0;
         return result;
      end

      err = int'($signed(item.target_temp)) - int'($signed(item.measured_temp));

      // first compute after reset or a clear only records the error
      if (!primed) begin
         prev_err = err;
         primed   = 1'b1;
         return result;
      end

      // a zero interval counts as one millisecond
      t = longint'(item.elapsed_ms);
      if (t == 0)
         t = 1;

      // accumulate, saturating at the 48-bit signed range
      s = integ_sum + longint'(err) * t;
      if (s > SUM_HIGH)
         s = SUM_HIGH;
      else if (s < SUM_LOW)
         s = SUM_LOW;

      // integral term limited to 0..ceiling
      i_num = longint'(gain_i) * s;
      if (i_num < 0)
         i_num = 0;
      if (i_num > DUTY_CEIL * TICK_SCALE)
         i_num = DUTY_CEIL * TICK_SCALE;

      derr     = err - prev_err;
      prev_err = err;

      den   = TICK_SCALE * t;
      total = longint'(gain_p) * longint'(err) * 1000 * t
            + i_num * t
            + longint'(gain_d) * longint'(derr) * 1000000;

      if (total > DUTY_CEIL * den) begin
         duty_full = DUTY_CEIL;
         clamp     = CLAMP_HIGH;
      end else if (total < 0) begin
         duty_full = 0;
         clamp     = CLAMP_LOW;
      end else begin
         duty_full = total / den;
         clamp     = CLAMP_NONE;
      end

      // back off this step's integration when saturated in the error's direction
      if (!((clamp == CLAMP_HIGH && gain_i != 0 && err > 0) ||
            (clamp == CLAMP_LOW && gain_i != 0 && err < 0)))
         integ_sum = s;

      result.duty        = DUTY_FIELD_W'(duty_full);
      result.clamp_state = clamp;
      return result;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         gain_p        = GAIN_P_RESET;
         gain_i        = GAIN_I_RESET;
         gain_d        = GAIN_D_RESET;
         integ_sum     = 0;
         prev_err      = 0;
         primed        = 1'b0;
         duty_queue.delete();
         fail_count    = 0;
         pending       = 0;
         checked_count = 0;
         high_count    = 0;
         low_count     = 0;
      end else begin
         // compare each response with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (duty_queue.size() == 0) begin
               report_mismatch($sformatf("response duty %0d clamp %0d with no request open",
                                         rsp_data.duty, rsp_data.clamp_state));
            end else begin
               want = duty_queue.pop_front();
               checked_count++;
               if (rsp_data.duty !== want.duty)
                  report_mismatch($sformatf("response %0d duty %0d, predicted %0d",
                                            checked_count, rsp_data.duty, want.duty));
               if (rsp_data.clamp_state !== want.clamp_state)
                  report_mismatch($sformatf("response %0d clamp state %0d, predicted %0d",
                                            checked_count, rsp_data.clamp_state,
                                            want.clamp_state));
               if (want.clamp_state == CLAMP_HIGH)
                  high_count++;
               else if (want.clamp_state == CLAMP_LOW)
                  low_count++;
            end
         end

         // track gain writes
         if (csr_write) begin
            case (csr_index)
               CSR_GAIN_P: gain_p = csr_data;
               CSR_GAIN_I: gain_i = csr_data;
               CSR_GAIN_D: gain_d = csr_data;
               default: ;
            endcase
         end

         // predict each accepted request
         if (req_valid && !req_stall)
            duty_queue.push_back(predict_duty(req_data));

         pending = duty_queue.size();
      end
   end

endmodule

[dv/pid_heater_controller_tb.sv]
`timescale 1ns / 1ps

module pid_heater_controller_tb;
   import phc_pkg::*;

   localparam int SETTLE_CYCLES  = 30;
   localparam int CLAMP_STEPS    = 4;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 110;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   phc_req_type            req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   phc_rsp_type            rsp_data;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_GAIN_P;
   logic [GAIN_W-1:0]      csr_data  = '0;

   int fail_count;
   int pending;
   int checked_count;
   int high_count;
   int low_count;
   int idle_pct      = 0;
   int stall_pct     = 0;
   int requests_sent = 0;
   int gain_settings = 0;

   pid_heater_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   pid_heater_controller_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .high_count    (high_count),
      .low_count     (low_count)
   );

   always #10 clock = ~clock;

   // stall the response channel at the current rate
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // give up well beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("pid_heater_controller_tb failed");
      $finish;
   end

   function automatic phc_req_type make_request(input logic op, input int meas, input int targ,
                                                input int ms);
      phc_req_type item;
      item.operation     = op;
      item.measured_temp = TEMP_W'(meas);
      item.target_temp   = TEMP_W'(targ);
      item.elapsed_ms    = ELAPSED_W'(ms);
      return item;
   endfunction

   // full-range temperature, biased towards the extremes
   function automatic int pick_temp();
      case ($urandom_range(7))
         0:       return -32768;
         1:       return 32767;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   function automatic phc_req_type noise_request();
      int ms;
      case ($urandom_range(7))
         0:       ms = 0;
         1:       ms = 65535;
         default: ms = $urandom_range(0, 65535);
      endcase
      return make_request($urandom_range(7) == 0, pick_temp(), pick_temp(), ms);
   endfunction

   // offer one request, idling at random first, and hold it until taken
   task automatic send_request(input phc_req_type item);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      requests_sent++;
   endtask

   // drop valid and wait for every open request to be answered
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_GAIN_P;
      csr_data  <= kp;
      @(negedge clock);
      csr_index <= CSR_GAIN_I;
      csr_data  <= ki;
      @(negedge clock);
      csr_index <= CSR_GAIN_D;
      csr_data  <= kd;
      @(negedge clock);
      csr_write <= 1'b0;
      gain_settings++;
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      if ($urandom_range(3) == 0)
         return GAIN_W'($urandom_range(0, 65535));
      return GAIN_W'($urandom_range(0, 8192));
   endfunction

   // heat-up run: usually a clear, then a warming probe against a fixed setpoint
   task automatic run_sequence(input int steps);
      int setpoint;
      int probe;
      int ms;
      setpoint = 16 * int'($urandom_range(0, 250)) - 400;
      probe    = setpoint - int'($urandom_range(0, 2400)) + 400;
      if ($urandom_range(3) != 0)
         send_request(make_request(1'b1, pick_temp(), pick_temp(), $urandom_range(0, 65535)));
      for (int k = 0; k < steps; k++) begin
         probe += int'($urandom_range(0, 60)) - 20;
         if ($urandom_range(15) == 0)
            probe += int'($urandom_range(0, 400)) - 200;
         case ($urandom_range(15))
            0:       ms = 0;
            1:       ms = $urandom_range(0, 65535);
            default: ms = $urandom_range(10, 600);
         endcase
         send_request(make_request(1'b0, probe, setpoint, ms));
      end
   endtask

   initial begin : stimulus
      int phase_start;

      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed requests at the reset gains, no idling
      send_request(make_request(1'b1, 1234, -1234, 77));
      send_request(make_request(1'b0, 400, 1440, 100));
      send_request(make_request(1'b0, 410, 1440, 0));
      send_request(make_request(1'b0, 1000, 1440, 250));
      send_request(make_request(1'b0, 1300, 1440, 65535));
      send_request(make_request(1'b0, -32768, 32767, 1000));
      send_request(make_request(1'b0, -32768, 32767, 1000));
      send_request(make_request(1'b0, 32767, -32768, 1000));
      send_request(make_request(1'b0, 32767, -32768, 0));
      send_request(make_request(1'b0, 1440, 1440, 500));
      send_request(make_request(1'b0, 32767, 32767, 65535));
      send_request(make_request(1'b0, -32768, -32768, 1));
      send_request(make_request(1'b1, -32768, 32767, 65535));
      send_request(make_request(1'b0, 1400, 1440, 200));
      for (int k = 0; k < 8; k++)
         send_request(make_request(1'b0, 1300 + 20 * k, 1440, 200));
      settle_idle();

      // clamp hard with no integral gain, so the sum keeps growing
      write_gains(16'hFFFF, 16'h0000, 16'hFFFF);
      send_request(make_request(1'b1, 0, 0, 0));
      repeat (CLAMP_STEPS + 1) send_request(make_request(1'b0, -32768, 32767, 65535));
      settle_idle();

      // expose the grown sum through the integral term alone
      write_gains(16'h0000, 16'h0001, 16'h0000);
      repeat (2) send_request(make_request(1'b0, -32768, 32767, 65535));
      send_request(make_request(1'b0, 32767, -32768, 1));
      settle_idle();

      // random phases over gain settings and idle/stall mixes
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle_idle();
         case (p % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 57; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 57; end
            default: begin idle_pct = 20; stall_pct = 20; end
         endcase
         case (p)
            0:       write_gains(16'h0000, 16'h0000, 16'h0000);
            1:       write_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
            2:       write_gains(GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
            3:       write_gains(16'hFFFF, 16'h0001, 16'h0000);
            default: write_gains(pick_gain(), pick_gain(), pick_gain());
         endcase
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(3) != 0)
               run_sequence($urandom_range(3, 28));
            else
               repeat ($urandom_range(1, 4)) send_request(noise_request());
         end
      end

      // drain and report
      settle_idle();
      $display("summary: %0d requests sent, %0d responses checked (%0d high, %0d low clamps)",
               requests_sent, checked_count, high_count, low_count);
      $display("summary: %0d gain settings, four idle/stall mixes, priming and clear cases",
               gain_settings);
      if (fail_count == 0)
         $display("pid_heater_controller_tb passed");
      else
         $display("pid_heater_controller_tb failed");
      $finish;
   end

endmodule

[pid_heater_controller.f]
hw/rtl/phc_pkg.sv
hw/rtl/phc_ctrl.sv
hw/rtl/phc_dp.sv
hw/rtl/pid_heater_controller.sv
hw/rtl/phc_checker.sv
dv/pid_heater_controller_checker.sv
dv/pid_heater_controller_tb.sv
